[src/c3f_pkg.sv]
`default_nettype none
package c3f_pkg;

  typedef logic [7:0] pix_t;

  // One window column: [0] upper line store, [1] lower line store, [2] newest row.
  typedef pix_t [2:0] col_t;

  // Work handed from the window to the arithmetic pipeline for one result.
  typedef struct packed {
    logic           compute;  // interior pixel: weighted sum, else result is zero
    logic           last;     // final beat of the frame
    col_t [2:0]     win;      // [0] oldest column, [2] newest column
  } tap_t;

  localparam int unsigned COEFF_W = 4;
  localparam int unsigned KERNEL_W = 36;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IMG_H_W = 12;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COEFFS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_SHIFT  = 8'd3;

  localparam logic [IMG_W_W-1:0]  RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [IMG_H_W-1:0]  RST_IMAGE_HEIGHT  = 12'd480;
  // Gaussian 1 2 1 / 2 4 2 / 1 2 1, first coefficient in the lowest nibble.
  localparam logic [KERNEL_W-1:0] RST_KERNEL_COEFFS = 36'h121242121;
  localparam logic [SHIFT_W-1:0]  RST_DIVIDE_SHIFT  = 3'd4;

endpackage
`default_nettype wire

[src/c3f_line_store.sv]
`default_nettype none
module c3f_line_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire c3f_pkg::pix_t wdata,
  input  wire logic [AW-1:0] raddr,
  output c3f_pkg::pix_t      rdata
);
  import c3f_pkg::*;

  pix_t mem [DEPTH];
  pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[src/c3f_cell.sv]
`default_nettype none
module c3f_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire c3f_pkg::col_t col_in,
  output c3f_pkg::col_t      col_out
);
  import c3f_pkg::*;

  col_t col_r;

  // Each cell holds one window column and takes its neighbour's on every pixel beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule
`default_nettype wire

[src/c3f_mac.sv]
`default_nettype none
module c3f_mac (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            load,
  input  wire c3f_pkg::tap_t                   tap,
  output logic                                 load_ready,
  input  wire logic [c3f_pkg::KERNEL_W-1:0]    kernel,
  input  wire logic [c3f_pkg::SHIFT_W-1:0]     shift,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output c3f_pkg::pix_t                        res_pixel,
  output logic                                 res_last
);
  import c3f_pkg::*;

  tap_t                 s1_r;
  logic                 v1_r;
  logic signed [14:0]   rs_r [3];
  logic signed [14:0]   rs_nxt [3];
  logic                 v2_r;
  logic                 c2_r;
  logic                 l2_r;
  logic                 vo_r;
  pix_t                 pix_r;
  pix_t                 pix_nxt;
  logic                 last_r;
  logic                 en_o;
  logic                 en_2;
  logic                 en_1;
  logic signed [16:0]   total;
  logic [15:0]          shifted;

  function automatic logic signed [3:0] coef_at(input logic [KERNEL_W-1:0] k,
                                                input int unsigned idx);
    return k[COEFF_W*idx +: COEFF_W];
  endfunction

  // A stage loads when it is empty or the stage after it is loading.
  assign en_o = !vo_r || res_ready;
  assign en_2 = !v2_r || en_o;
  assign en_1 = !v1_r || en_2;
  assign load_ready = en_1;

  always_comb begin
    logic signed [12:0] prod [3];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] = 13'(coef_at(kernel, unsigned'(r * 3 + c))
                      * $signed({1'b0, s1_r.win[c][r]}));
      end
      rs_nxt[r] = 15'(prod[0]) + 15'(prod[1]) + 15'(prod[2]);
    end
  end

  always_comb begin
    total   = 17'(rs_r[0]) + 17'(rs_r[1]) + 17'(rs_r[2]);
    shifted = total[15:0] >> shift;
    pix_nxt = '0;
    if (c2_r && total > 17'sd0) begin
      pix_nxt = (shifted > 16'd255) ? 8'd255 : shifted[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en_1) v1_r <= load;
      if (en_2) v2_r <= v1_r;
      if (en_o) vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_1) s1_r <= tap;
    if (en_2) begin
      rs_r <= rs_nxt;
      c2_r <= s1_r.compute;
      l2_r <= s1_r.last;
    end
    if (en_o) begin
      pix_r  <= pix_nxt;
      last_r <= l2_r;
    end
  end

  assign res_valid = vo_r;
  assign res_pixel = pix_r;
  assign res_last  = last_r;

endmodule
`default_nettype wire

[src/conv3x3_clamped_filter_top.sv]
// Channel  Direction  Beat contents
// in_      slave      tuser = mode (1 flushes a pending border pixel), tdata = pixel_in
// out_     master     tdata = pixel_out, tlast = frame_last
// cfg_     slave      cfg_index selects the register, cfg_data carries its value
//
// One input beat is accepted per clock while in_tready is high.
// Each line store has its own read and write port and is read one column ahead, so the
// data for the next pixel is ready while the current one is written back.
// Reset clears counters, window cells and pipeline valid bits; line stores are not cleared.
// A stalled output fills the three pipeline stages before in_tready falls.
`default_nettype none
module conv3x3_clamped_filter_top #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] pixel_in
  input  wire logic                             in_tuser,   // [0] mode
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [7:0]                            out_tdata,  // [7:0] pixel_out
  output logic                                  out_tlast,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [c3f_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [c3f_pkg::KERNEL_W-1:0]     cfg_data
);
  import c3f_pkg::*;

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ?
                               $clog2(MAX_WIDTH + 1) : IMG_W_W;
  localparam int unsigned PW = $clog2(MAX_WIDTH + 2);

  logic [IMG_W_W-1:0]  width_r;
  logic [IMG_H_W-1:0]  height_r;
  logic [KERNEL_W-1:0] kernel_r;
  logic [SHIFT_W-1:0]  shift_r;

  logic [CW-1:0]       col_r, col_nxt;
  logic [IMG_H_W-1:0]  row_r, row_nxt;
  logic [PW-1:0]       pend_r, pend_nxt;

  logic [EW-1:0]       w_eff;
  logic [IMG_H_W-1:0]  h_eff;
  logic [EW-1:0]       col_plus;
  logic [IMG_H_W:0]    row_plus;
  logic                cfg_fire;
  logic                geo_write;
  logic                accept;
  logic                pix_accept;
  logic                has_real;
  logic                emit;
  tap_t                tap;
  col_t                column;
  col_t                cell0_col, cell1_col;
  pix_t                upper_rd, lower_rd;
  logic                mac_ready;

  function automatic pix_t pixel_in_of(input logic [7:0] d);
    return d;
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign geo_write  = cfg_fire && (cfg_index == REG_IMAGE_WIDTH ||
                                   cfg_index == REG_IMAGE_HEIGHT);
  assign in_tready  = mac_ready;
  assign accept     = in_tvalid && in_tready;
  assign pix_accept = accept && !in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      kernel_r <= RST_KERNEL_COEFFS;
      shift_r  <= RST_DIVIDE_SHIFT;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   width_r  <= cfg_data[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:  height_r <= cfg_data[IMG_H_W-1:0];
        REG_KERNEL_COEFFS: kernel_r <= cfg_data;
        REG_DIVIDE_SHIFT:  shift_r  <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < IMG_W_W'(3)) begin
      w_eff = EW'(3);
    end else if (EW'(width_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_r);
    end
    h_eff = (height_r < IMG_H_W'(3)) ? IMG_H_W'(3) : height_r;
  end

  assign column   = '{pixel_in_of(in_tdata), lower_rd, upper_rd};
  assign col_plus = EW'(col_r) + EW'(1);
  assign row_plus = {1'b0, row_r} + (IMG_H_W + 1)'(1);
  assign has_real = (row_r >= IMG_H_W'(2)) || (row_r == IMG_H_W'(1) && col_r != '0);

  always_comb begin
    col_nxt     = col_r;
    row_nxt     = row_r;
    pend_nxt    = pend_r;
    emit        = 1'b0;
    tap.compute = 1'b0;
    tap.last    = 1'b0;
    tap.win     = '{column, cell1_col, cell0_col};
    if (geo_write) begin
      col_nxt  = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (accept) begin
      if (in_tuser) begin
        if (pend_r != '0) begin
          emit     = 1'b1;
          tap.last = (pend_r == PW'(1));
          pend_nxt = pend_r - PW'(1);
        end
      end else begin
        if (has_real) begin
          emit        = 1'b1;
          tap.compute = (row_r >= IMG_H_W'(2)) && (col_r >= CW'(2));
          pend_nxt    = '0;
        end else if (pend_r != '0) begin
          // Beats early in a frame carry out the previous frame's border tail.
          emit     = 1'b1;
          tap.last = (pend_r == PW'(1));
          pend_nxt = pend_r - PW'(1);
        end
        if (col_plus >= w_eff) begin
          col_nxt = '0;
          if (row_plus >= {1'b0, h_eff}) begin
            row_nxt  = '0;
            pend_nxt = PW'(w_eff) + PW'(1);
          end else begin
            row_nxt = row_plus[IMG_H_W-1:0];
          end
        end else begin
          col_nxt = col_plus[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Both stores are read at the next column so the data is ready when its pixel arrives.
  c3f_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk   (clk),
    .we    (pix_accept),
    .waddr (col_r),
    .wdata (lower_rd),
    .raddr (col_nxt),
    .rdata (upper_rd)
  );

  c3f_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
    .clk   (clk),
    .we    (pix_accept),
    .waddr (col_r),
    .wdata (pixel_in_of(in_tdata)),
    .raddr (col_nxt),
    .rdata (lower_rd)
  );

  c3f_cell u_cell1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (pix_accept),
    .col_in   (column),
    .col_out  (cell1_col)
  );

  c3f_cell u_cell0 (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (pix_accept),
    .col_in   (cell1_col),
    .col_out  (cell0_col)
  );

  c3f_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .tap        (tap),
    .load_ready (mac_ready),
    .kernel     (kernel_r),
    .shift      (shift_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_pixel  (out_tdata),
    .res_last   (out_tlast)
  );

endmodule
`default_nettype wire
